// ===== src/esw_pkg.sv =====
// ----------------------------------------------------------------------------
// esw_pkg
// Shared types and codes for the EMSI sequence waiter.
// ----------------------------------------------------------------------------
package esw_pkg;

    localparam int SEQ_LEN   = 12;
    localparam int CNT_W     = $clog2(SEQ_LEN + 1);
    localparam int CHAR_W    = 7;

    typedef logic [CHAR_W-1:0]             t_char;
    typedef logic [SEQ_LEN-1:0][CHAR_W-1:0] t_word;

    // item kinds
    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_TICK    = 3'd1;
    localparam logic [2:0] KIND_LINEERR = 3'd2;
    localparam logic [2:0] KIND_MTIMEOUT = 3'd3;
    localparam logic [2:0] KIND_START   = 3'd4;

    // verdicts
    localparam logic [2:0] VERDICT_WAIT    = 3'd0;
    localparam logic [2:0] VERDICT_ACK     = 3'd1;
    localparam logic [2:0] VERDICT_RESEND  = 3'd2;
    localparam logic [2:0] VERDICT_RESTART = 3'd3;
    localparam logic [2:0] VERDICT_FAIL    = 3'd4;

    // send requests
    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_INQ  = 2'd1;
    localparam logic [1:0] SEND_ACK  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CALLER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SYNC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SYNC   = 2'd2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] SHORT_SYNC_RST = 8'd10;
    localparam logic [7:0] LONG_SYNC_RST  = 8'd20;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] rx_byte;
        logic       retry_flag;
    } t_in_item;

    typedef struct packed {
        logic [2:0] verdict;
        logic [1:0] send_request;
        logic       unexpected_seq;
        logic       bad_char;
    } t_out_item;

    typedef struct packed {
        logic       caller_mode;
        logic [7:0] short_sync_ticks;
        logic [7:0] long_sync_ticks;
    } t_cfg;

    typedef struct packed {
        logic req;
        logic ack;
        logic nak;
        logic inq;
        logic dat;
    } t_word_hits;

endpackage

// ===== src/emsi_sequence_waiter.sv =====
// ----------------------------------------------------------------------------
// emsi_sequence_waiter
// Watches the line after an EMSI data packet and decides what happens next.
// ----------------------------------------------------------------------------
// Takes one item per clock unless held by o_in_stall, and gives one result per
// item. Each item passes an input register, one pass of classify-and-update
// logic and a result register, from which its result is offered. The result
// register frees as it is taken, so a stalled output holds back input only
// while both registers are full. Configuration writes apply on the next cycle.
module emsi_sequence_waiter
    import esw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_result;
    logic      out_free;
    logic      fire;
    logic      accept;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{caller_mode: 1'b0, short_sync_ticks: SHORT_SYNC_RST,
                       long_sync_ticks: LONG_SYNC_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CALLER_MODE: r_cfg.caller_mode      <= i_cfg_data[0];
                CFG_SHORT_SYNC:  r_cfg.short_sync_ticks <= i_cfg_data;
                CFG_LONG_SYNC:   r_cfg.long_sync_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_in_item <= i_in_item;
        if (fire)   r_out_item <= n_result;
    end

    esw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (n_result)
    );

endmodule

// ===== src/esw_word_match.sv =====
// ----------------------------------------------------------------------------
// esw_word_match
// Compares a complete upper-cased word against the known EMSI words.
// ----------------------------------------------------------------------------
module esw_word_match
    import esw_pkg::*;
(
    input  t_word      i_word,
    output t_word_hits o_hits
);

    localparam int DAT_LEN = 8;

    localparam t_char WORD_REQ [SEQ_LEN] = '{7'h45, 7'h4D, 7'h53, 7'h49, 7'h5F, 7'h52,
                                             7'h45, 7'h51, 7'h41, 7'h37, 7'h37, 7'h45};
    localparam t_char WORD_ACK [SEQ_LEN] = '{7'h45, 7'h4D, 7'h53, 7'h49, 7'h5F, 7'h41,
                                             7'h43, 7'h4B, 7'h41, 7'h34, 7'h39, 7'h30};
    localparam t_char WORD_NAK [SEQ_LEN] = '{7'h45, 7'h4D, 7'h53, 7'h49, 7'h5F, 7'h4E,
                                             7'h41, 7'h4B, 7'h45, 7'h45, 7'h43, 7'h33};
    localparam t_char WORD_INQ [SEQ_LEN] = '{7'h45, 7'h4D, 7'h53, 7'h49, 7'h5F, 7'h49,
                                             7'h4E, 7'h51, 7'h43, 7'h38, 7'h31, 7'h36};
    localparam t_char WORD_DAT [DAT_LEN] = '{7'h45, 7'h4D, 7'h53, 7'h49, 7'h5F, 7'h44,
                                             7'h41, 7'h54};

    always_comb begin
        o_hits = '{req: 1'b1, ack: 1'b1, nak: 1'b1, inq: 1'b1, dat: 1'b1};
        for (int i = 0; i < SEQ_LEN; i++) begin
            if (i_word[i] != WORD_REQ[i]) o_hits.req = 1'b0;
            if (i_word[i] != WORD_ACK[i]) o_hits.ack = 1'b0;
            if (i_word[i] != WORD_NAK[i]) o_hits.nak = 1'b0;
            if (i_word[i] != WORD_INQ[i]) o_hits.inq = 1'b0;
        end
        for (int i = 0; i < DAT_LEN; i++) begin
            if (i_word[i] != WORD_DAT[i]) o_hits.dat = 1'b0;
        end
    end

endmodule

// ===== src/esw_core.sv =====
// ----------------------------------------------------------------------------
// esw_core
// Sequence collector, sync timer and verdict logic; one item per fire.
// ----------------------------------------------------------------------------
module esw_core
    import esw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam logic [7:0] CH_XON  = 8'h11;
    localparam logic [7:0] CH_XOFF = 8'h13;
    localparam logic [7:0] CH_STAR = 8'h2A;

    t_char             r_chars [SEQ_LEN];
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_in_seq, n_in_seq;
    logic [7:0]        r_sync, n_sync;
    logic              r_nak_seen, n_nak_seen;

    t_char             up_char;
    logic              store;
    logic              closing;
    t_word             word;
    t_word_hits        hits;

    // upper-cased 7-bit character
    always_comb begin
        up_char = i_item.rx_byte[CHAR_W-1:0];
        if (i_item.rx_byte inside {[8'h61:8'h7A]}) begin
            up_char[5] = 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < SEQ_LEN - 1; i++) begin
            word[i] = r_chars[i];
        end
        word[SEQ_LEN-1] = up_char;
    end

    esw_word_match u_match (
        .i_word (word),
        .o_hits (hits)
    );

    always_comb begin
        n_count    = r_count;
        n_in_seq   = r_in_seq;
        n_sync     = r_sync;
        n_nak_seen = r_nak_seen;
        store      = 1'b0;
        closing    = 1'b0;
        o_result   = '{verdict: VERDICT_WAIT, send_request: SEND_NONE,
                       unexpected_seq: 1'b0, bad_char: 1'b0};
        case (i_item.kind)
            KIND_START: begin
                n_sync  = i_item.retry_flag ? i_cfg.long_sync_ticks
                                            : i_cfg.short_sync_ticks;
                n_count = '0;
            end
            KIND_TICK: begin
                if (r_sync <= 8'd1) begin
                    n_sync           = '0;
                    o_result.verdict = VERDICT_RESEND;
                end else begin
                    n_sync = r_sync - 8'd1;
                end
            end
            KIND_LINEERR, KIND_MTIMEOUT: begin
                o_result.verdict = VERDICT_FAIL;
            end
            KIND_BYTE: begin
                if (i_item.rx_byte == CH_XON || i_item.rx_byte == CH_XOFF) begin
                    // flow control, dropped
                end else if (i_item.rx_byte == CH_STAR) begin
                    n_count  = '0;
                    n_in_seq = 1'b1;
                end else if (r_in_seq && (i_item.rx_byte inside {[8'h21:8'h7D]})) begin
                    store   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    closing = (r_count == CNT_W'(SEQ_LEN - 1));
                end else if (r_in_seq) begin
                    n_in_seq          = 1'b0;
                    o_result.bad_char = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (closing) begin
            n_in_seq = 1'b0;
            if (hits.req) begin
                // keep waiting
            end else if (hits.ack) begin
                o_result.verdict = VERDICT_ACK;
            end else if (hits.nak) begin
                if (!r_nak_seen) o_result.verdict = VERDICT_RESEND;
                n_nak_seen = 1'b1;
            end else if (hits.inq) begin
                o_result.verdict = VERDICT_RESTART;
            end else if (hits.dat) begin
                if (i_cfg.caller_mode) begin
                    o_result.verdict      = VERDICT_RESEND;
                    o_result.send_request = SEND_INQ;
                end else begin
                    o_result.send_request = SEND_ACK;
                end
            end else begin
                o_result.unexpected_seq = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_in_seq   <= 1'b0;
            r_sync     <= '0;
            r_nak_seen <= 1'b0;
        end else if (i_fire) begin
            r_count    <= n_count;
            r_in_seq   <= n_in_seq;
            r_sync     <= n_sync;
            r_nak_seen <= n_nak_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SEQ_LEN; i++) begin
            if (i_fire && store && r_count == CNT_W'(i)) begin
                r_chars[i] <= up_char;
            end
        end
    end

endmodule
